>>> hw/rtl/stride_scheduler_top_defines.svh
// Assertion macros used by the stride scheduler RTL.
`ifndef STRIDE_SCHEDULER_TOP_DEFINES_SVH
`define STRIDE_SCHEDULER_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define SS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define SS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/ss_pkg.sv
// Types and constants of the stride scheduler.
package ss_pkg;

    localparam int SLOTS     = 64;
    localparam int SLOT_W    = $clog2(SLOTS);
    localparam int PASS_W    = 32;
    localparam int PRIO_W    = 16;
    localparam int SLICE_W   = 8;
    localparam int FUNC_W    = 2;
    localparam int SLOT_IN_W = 6;
    localparam int COUNT_W   = 7;
    localparam int QUO_W     = 31;
    localparam int DIVCNT_W  = 5;

    localparam logic [PASS_W-1:0]  STRIDE_BIG   = 32'h7FFF_FFFF;
    localparam logic [SLICE_W-1:0] RELOAD_RESET = 8'd5;
    localparam logic [SLOT_W-1:0]  SCAN_LAST    = SLOT_W'(SLOTS - 1);

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ENQ  = 2'd0,
        FUNC_DEQ  = 2'd1,
        FUNC_PICK = 2'd2,
        FUNC_TICK = 2'd3
    } func_t;

    typedef struct packed {
        logic [PASS_W-1:0]  pass;
        logic [PRIO_W-1:0]  prio;
        logic [SLICE_W-1:0] slice;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    localparam entry_t ENTRY_RESET = '{pass: '0, prio: 16'd1, slice: '0};

endpackage

>>> hw/rtl/ss_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module ss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> hw/rtl/stride_scheduler_top.sv
// Stride scheduler run queue: slot table in RAM, scan, stride divider.
//
//   channel   direction  handshake            payload
//   request   in         start & !busy        func, slot, priority_req
//   result    out        done (one cycle)     found, chosen_slot, resched, ready_count
//   config    in         cfg_valid & ready    cfg_data (slice_reload)
//
// Dequeue: the result comes in the cycle after the request. Enqueue and tick:
// table read, then write back. Pick: a one-entry-per-cycle table scan, then the
// 31-step restoring divider for 0x7FFFFFFF/priority and a write back of the pass;
// when no task is ready the divider and the write back are skipped.
// Reset clears ready and written bits at once; no clearing pass is needed.
// busy is high while a request is in flight; the result cannot be stalled.
`include "stride_scheduler_top_defines.svh"

module stride_scheduler_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [ss_pkg::FUNC_W-1:0]     func,
    input  logic [ss_pkg::SLOT_IN_W-1:0]  slot,
    input  logic [ss_pkg::PRIO_W-1:0]     priority_req,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [ss_pkg::SLICE_W-1:0]    cfg_data,
    output logic                          done,
    output logic                          found,
    output logic [ss_pkg::SLOT_IN_W-1:0]  chosen_slot,
    output logic                          resched,
    output logic [ss_pkg::COUNT_W-1:0]    ready_count
);

    import ss_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_RMW   = 6'b000010,
        S_SCAN  = 6'b000100,
        S_DRAIN = 6'b001000,
        S_DIV   = 6'b010000,
        S_WB    = 6'b100000
    } state_t;

    state_t                 state_reg, state_next;
    func_t                  func_reg, func_next;
    logic [SLOT_W-1:0]      slot_reg, slot_next;
    logic [PRIO_W-1:0]      prio_reg, prio_next;
    logic [SLOTS-1:0]       rdy_reg, rdy_next;
    logic [SLOTS-1:0]       init_reg, init_next;
    logic [COUNT_W-1:0]     count_reg, count_next;
    logic [SLICE_W-1:0]     reload_reg;
    logic [SLOT_W-1:0]      scan_reg, scan_next;
    logic                   cmp_vld_reg, cmp_vld_next;
    logic [SLOT_W-1:0]      cmp_idx_reg, cmp_idx_next;
    logic                   have_reg, have_next;
    logic [SLOT_W-1:0]      best_idx_reg, best_idx_next;
    entry_t                 best_reg, best_next;
    logic [DIVCNT_W-1:0]    div_cnt_reg, div_cnt_next;
    logic [PRIO_W-1:0]      rem_reg, rem_next;
    logic [QUO_W-1:0]       quo_reg, quo_next;
    logic                   done_reg, done_next;
    logic                   found_reg, found_next;
    logic [SLOT_IN_W-1:0]   chosen_reg, chosen_next;
    logic                   resched_reg, resched_next;

    logic                   ram_we, ram_re;
    logic [SLOT_W-1:0]      ram_waddr, ram_raddr;
    entry_t                 ram_wdata, rd_entry;
    logic [ENTRY_W-1:0]     ram_rdata;

    logic [SLOT_W-1:0]      slot_addr_in;
    logic                   in_ok;
    entry_t                 eff_entry;
    logic [SLICE_W-1:0]     slice_dec;
    logic [PASS_W-1:0]      pass_diff;
    logic                   cmp_upd;
    logic [PRIO_W:0]        divisor;
    logic [PRIO_W:0]        rem_sh;

    ss_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_entry     = entry_t'(ram_rdata);
    assign slot_addr_in = SLOT_W'(slot);
    assign in_ok        = 32'(slot) < SLOTS;

    // entries never written read as their reset value
    assign eff_entry = init_reg[slot_reg] ? rd_entry : ENTRY_RESET;
    assign slice_dec = (eff_entry.slice != '0) ? eff_entry.slice - 8'd1 : '0;

    // wrapping signed compare against the current best
    assign pass_diff = rd_entry.pass - best_reg.pass;
    assign cmp_upd   = cmp_vld_reg && rdy_reg[cmp_idx_reg] && (!have_reg || pass_diff[PASS_W-1]);

    assign divisor = {1'b0, (best_reg.prio == '0) ? 16'd1 : best_reg.prio};
    assign rem_sh  = {rem_reg, STRIDE_BIG[div_cnt_reg]};

    always_comb
    begin
        state_next    = state_reg;
        func_next     = func_reg;
        slot_next     = slot_reg;
        prio_next     = prio_reg;
        rdy_next      = rdy_reg;
        init_next     = init_reg;
        count_next    = count_reg;
        scan_next     = scan_reg;
        cmp_vld_next  = cmp_vld_reg;
        cmp_idx_next  = cmp_idx_reg;
        have_next     = have_reg;
        best_idx_next = best_idx_reg;
        best_next     = best_reg;
        div_cnt_next  = div_cnt_reg;
        rem_next      = rem_reg;
        quo_next      = quo_reg;
        done_next     = 1'b0;
        found_next    = found_reg;
        chosen_next   = chosen_reg;
        resched_next  = resched_reg;
        ram_we        = 1'b0;
        ram_waddr     = slot_reg;
        ram_wdata     = eff_entry;
        ram_re        = 1'b0;
        ram_raddr     = slot_addr_in;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    func_next = func_t'(func);
                    slot_next = slot_addr_in;
                    prio_next = priority_req;
                    case (func_t'(func))
                        FUNC_DEQ:
                        begin
                            if (in_ok && rdy_reg[slot_addr_in])
                            begin
                                rdy_next[slot_addr_in] = 1'b0;
                                count_next = count_reg - 7'd1;
                            end
                            done_next    = 1'b1;
                            found_next   = 1'b0;
                            chosen_next  = '0;
                            resched_next = 1'b0;
                        end
                        FUNC_PICK:
                        begin
                            scan_next    = '0;
                            cmp_vld_next = 1'b0;
                            have_next    = 1'b0;
                            state_next   = S_SCAN;
                        end
                        default:
                        begin
                            if (in_ok)
                            begin
                                ram_re     = 1'b1;
                                state_next = S_RMW;
                            end
                            else
                            begin
                                done_next    = 1'b1;
                                found_next   = 1'b0;
                                chosen_next  = '0;
                                resched_next = 1'b0;
                            end
                        end
                    endcase
                end
            end

            S_RMW:
            begin
                ram_we              = 1'b1;
                init_next[slot_reg] = 1'b1;
                done_next           = 1'b1;
                found_next          = 1'b0;
                chosen_next         = '0;
                if (func_reg == FUNC_ENQ)
                begin
                    ram_wdata = '{pass: eff_entry.pass, prio: prio_reg, slice: reload_reg};
                    if (!rdy_reg[slot_reg])
                    begin
                        rdy_next[slot_reg] = 1'b1;
                        count_next = count_reg + 7'd1;
                    end
                    resched_next = 1'b0;
                end
                else
                begin
                    ram_wdata = '{pass: eff_entry.pass, prio: eff_entry.prio, slice: slice_dec};
                    resched_next = (slice_dec == '0);
                end
                state_next = S_IDLE;
            end

            S_SCAN:
            begin
                ram_re       = 1'b1;
                ram_raddr    = scan_reg;
                cmp_vld_next = 1'b1;
                cmp_idx_next = scan_reg;
                if (cmp_upd)
                begin
                    have_next     = 1'b1;
                    best_idx_next = cmp_idx_reg;
                    best_next     = rd_entry;
                end
                if (scan_reg == SCAN_LAST)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    scan_next = scan_reg + SLOT_W'(1);
                end
            end

            S_DRAIN:
            begin
                cmp_vld_next = 1'b0;
                if (cmp_upd)
                begin
                    have_next     = 1'b1;
                    best_idx_next = cmp_idx_reg;
                    best_next     = rd_entry;
                end
                if (have_reg || cmp_upd)
                begin
                    div_cnt_next = DIVCNT_W'(QUO_W - 1);
                    rem_next     = '0;
                    quo_next     = '0;
                    state_next   = S_DIV;
                end
                else
                begin
                    done_next    = 1'b1;
                    found_next   = 1'b0;
                    chosen_next  = '0;
                    resched_next = 1'b0;
                    state_next   = S_IDLE;
                end
            end

            S_DIV:
            begin
                // restoring division, one quotient bit per cycle
                if (rem_sh >= divisor)
                begin
                    rem_next = PRIO_W'(rem_sh - divisor);
                    quo_next = {quo_reg[QUO_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = PRIO_W'(rem_sh);
                    quo_next = {quo_reg[QUO_W-2:0], 1'b0};
                end
                if (div_cnt_reg == '0)
                begin
                    state_next = S_WB;
                end
                else
                begin
                    div_cnt_next = div_cnt_reg - DIVCNT_W'(1);
                end
            end

            S_WB:
            begin
                ram_we       = 1'b1;
                ram_waddr    = best_idx_reg;
                ram_wdata    = '{pass: best_reg.pass + {1'b0, quo_reg},
                                 prio: best_reg.prio, slice: best_reg.slice};
                done_next    = 1'b1;
                found_next   = 1'b1;
                chosen_next  = SLOT_IN_W'(best_idx_reg);
                resched_next = 1'b0;
                state_next   = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            rdy_reg     <= '0;
            init_reg    <= '0;
            count_reg   <= '0;
            reload_reg  <= RELOAD_RESET;
            cmp_vld_reg <= 1'b0;
            have_reg    <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            rdy_reg     <= rdy_next;
            init_reg    <= init_next;
            count_reg   <= count_next;
            cmp_vld_reg <= cmp_vld_next;
            have_reg    <= have_next;
            done_reg    <= done_next;
            if (cfg_valid && cfg_ready)
            begin
                reload_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg     <= func_next;
        slot_reg     <= slot_next;
        prio_reg     <= prio_next;
        scan_reg     <= scan_next;
        cmp_idx_reg  <= cmp_idx_next;
        best_idx_reg <= best_idx_next;
        best_reg     <= best_next;
        div_cnt_reg  <= div_cnt_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        found_reg    <= found_next;
        chosen_reg   <= chosen_next;
        resched_reg  <= resched_next;
    end

    assign busy        = (state_reg != S_IDLE);
    assign cfg_ready   = 1'b1;
    assign done        = done_reg;
    assign found       = found_reg;
    assign chosen_slot = chosen_reg;
    assign resched     = resched_reg;
    assign ready_count = count_reg;

    `SS_ASSERT_NOW(a_done_idle, done, !busy, "result strobe while a request is in flight")
    `SS_ASSERT_NOW(a_count_flags, 1'b1, ready_count == 7'($countones(rdy_reg)), "ready count off")
    `SS_ASSERT_NEXT(a_deq_fast, start && !busy && func_t'(func) == FUNC_DEQ, done, "dequeue late")
    `SS_ASSERT_NOW(a_wr_state, ram_we, state_reg == S_RMW || state_reg == S_WB, "stray table write")

endmodule
